### rtl/core/czrd_pkg.sv
// Package for the camera zoom reply deframer.
// Holds the frame phase type, configuration codes, reset values and the
// structs passed between the parser, the result stage and the top level.
package czrd_pkg;

    localparam int BYTE_W     = 8;
    localparam int POSITION_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_ADDRESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WANTED_COMMAND   = 1'b1;

    localparam logic [BYTE_W-1:0] EXPECTED_ADDRESS_RST = 8'h01;
    localparam logic [BYTE_W-1:0] WANTED_COMMAND_RST   = 8'h6D;

    typedef enum logic [6:0] {
        PH_HUNT   = 7'b0000001,
        PH_SYNCED = 7'b0000010,
        PH_CMD1   = 7'b0000100,
        PH_CMD2   = 7'b0001000,
        PH_HIGH   = 7'b0010000,
        PH_LOW    = 7'b0100000,
        PH_CHECK  = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] expected_address;
        logic [BYTE_W-1:0] wanted_command;
    } cfg_t;

    typedef struct packed {
        logic                  valid;
        logic [POSITION_W-1:0] position_value;
    } result_t;

endpackage

### rtl/core/camera_zoom_reply_deframer_top.sv
// A result beat enters the output register, or the skid entry while m_ is stalled.
// Throughput: one byte per cycle; s_ready is registered and drops only while
// two finished results wait (output register and skid entry both full).
// Reset: aresetn is synchronous, active low; it returns to sync hunt, empties the
// result stage and restores expected_address to 0x01 and wanted_command to 0x6D.
module camera_zoom_reply_deframer_top
    import czrd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [BYTE_W-1:0]     s_rx_byte,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [POSITION_W-1:0] m_position_value,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t    cfg_reg;
    result_t result;
    logic    byte_fire;

    assign byte_fire = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.expected_address <= EXPECTED_ADDRESS_RST;
            cfg_reg.wanted_command   <= WANTED_COMMAND_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_EXPECTED_ADDRESS: cfg_reg.expected_address <= cfg_wdata;
                CFG_WANTED_COMMAND:   cfg_reg.wanted_command   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    czrd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_fire (byte_fire),
        .rx_byte   (s_rx_byte),
        .cfg       (cfg_reg),
        .result    (result)
    );

    czrd_result_stage u_result (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_result        (result),
        .in_ready         (s_ready),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_position_value (m_position_value)
    );

endmodule

### rtl/core/czrd_parser.sv
// Frame parser: phase state machine, running checksum and held frame bytes.
// Depends on czrd_pkg; emits at most one result per accepted beat.
module czrd_parser
    import czrd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              byte_fire,
    input  logic [BYTE_W-1:0] rx_byte,
    input  cfg_t              cfg,
    output result_t           result
);

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic [BYTE_W-1:0] cmd_reg, cmd_next;
    logic [BYTE_W-1:0] high_reg, high_next;
    logic [BYTE_W-1:0] low_reg, low_next;

    always_comb begin
        phase_next            = phase_reg;
        sum_next              = sum_reg;
        cmd_next              = cmd_reg;
        high_next             = high_reg;
        low_next              = low_reg;
        result.valid          = 1'b0;
        result.position_value = {high_reg, low_reg};
        if (byte_fire) begin
            unique case (phase_reg)
                PH_SYNCED: begin
                    if (rx_byte == cfg.expected_address) begin
                        sum_next   = rx_byte;
                        phase_next = PH_CMD1;
                    end else if (rx_byte == SYNC_BYTE) begin
                        phase_next = PH_SYNCED;
                    end else begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_CMD1: begin
                    sum_next   = sum_reg + rx_byte;
                    phase_next = PH_CMD2;
                end
                PH_CMD2: begin
                    cmd_next   = rx_byte;
                    sum_next   = sum_reg + rx_byte;
                    phase_next = PH_HIGH;
                end
                PH_HIGH: begin
                    high_next  = rx_byte;
                    sum_next   = sum_reg + rx_byte;
                    phase_next = PH_LOW;
                end
                PH_LOW: begin
                    low_next   = rx_byte;
                    sum_next   = sum_reg + rx_byte;
                    phase_next = PH_CHECK;
                end
                PH_CHECK: begin
                    result.valid = (sum_reg == rx_byte) && (cmd_reg == cfg.wanted_command);
                    phase_next   = PH_HUNT;
                end
                default: begin
                    phase_next = (rx_byte == SYNC_BYTE) ? PH_SYNCED : PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
        end else begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg  <= sum_next;
        cmd_reg  <= cmd_next;
        high_reg <= high_next;
        low_reg  <= low_next;
    end

`ifndef SYNTHESIS
    a_result_from_check: assert property (@(posedge aclk) disable iff (!aresetn)
        result.valid |-> (byte_fire && phase_reg == PH_CHECK))
        else $error("result raised outside checksum beat");

    a_addr_opens_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (byte_fire && phase_reg == PH_SYNCED && rx_byte == cfg.expected_address)
        |=> phase_reg == PH_CMD1)
        else $error("address beat did not open a frame");

    a_phase_holds_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !byte_fire |=> $stable(phase_reg))
        else $error("phase moved without a beat");
`endif

endmodule

### rtl/core/czrd_result_stage.sv
// Result stage: output register plus one skid entry toward the m_ channel.
// Depends on czrd_pkg; in_ready is registered and drops only when both are full.
module czrd_result_stage
    import czrd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  result_t               in_result,
    output logic                  in_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [POSITION_W-1:0] m_position_value
);

    logic                  main_valid_reg, main_valid_next;
    logic [POSITION_W-1:0] main_data_reg, main_data_next;
    logic                  skid_valid_reg, skid_valid_next;
    logic [POSITION_W-1:0] skid_data_reg, skid_data_next;
    logic                  m_fire;

    assign m_fire           = main_valid_reg && m_ready;
    assign in_ready         = !skid_valid_reg;
    assign m_valid          = main_valid_reg;
    assign m_position_value = main_data_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        main_data_next  = main_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (m_fire) begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (main_valid_reg) begin
            if (m_fire) begin
                main_valid_next = in_result.valid;
                main_data_next  = in_result.position_value;
            end else if (in_result.valid) begin
                skid_valid_next = 1'b1;
                skid_data_next  = in_result.position_value;
            end
        end else begin
            main_valid_next = in_result.valid;
            main_data_next  = in_result.position_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

`ifndef SYNTHESIS
    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held with empty output register");

    a_no_result_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        in_result.valid |-> in_ready)
        else $error("result arrived while stage full");

    a_drain_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_fire && !skid_valid_reg && !in_result.valid) |=> !main_valid_reg)
        else $error("output register not emptied after drain");
`endif

endmodule

### tb/czrd_reply_checker.sv
// Checker for the camera zoom reply deframer: tracks config writes and
// byte beats, predicts zoom position beats and compares them in order.
// Depends on czrd_pkg for widths, phase encoding, register codes and resets.
module czrd_reply_checker
    import czrd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [BYTE_W-1:0]     s_rx_byte,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [POSITION_W-1:0] m_position_value,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int unsigned           mismatches,
    output int unsigned           positions_outstanding
);

    logic [BYTE_W-1:0]     address_sel;
    logic [BYTE_W-1:0]     command_sel;
    phase_t                phase;
    logic [BYTE_W-1:0]     frame_sum;
    logic [BYTE_W-1:0]     frame_command;
    logic [BYTE_W-1:0]     frame_high;
    logic [BYTE_W-1:0]     frame_low;
    logic [POSITION_W-1:0] positions_due[$];

    task automatic report_mismatch(input string what);
        $display("%0t reply check: %s", $time, what);
        mismatches++;
    endtask

    function automatic void take_reply_byte(input logic [BYTE_W-1:0] b);
        case (phase)
            PH_SYNCED: begin
                if (b == address_sel) begin
                    frame_sum = b;
                    phase = PH_CMD1;
                end else if (b == SYNC_BYTE) begin
                    phase = PH_SYNCED;
                end else begin
                    phase = PH_HUNT;
                end
            end
            PH_CMD1: begin
                frame_sum = frame_sum + b;
                phase = PH_CMD2;
            end
            PH_CMD2: begin
                frame_command = b;
                frame_sum = frame_sum + b;
                phase = PH_HIGH;
            end
            PH_HIGH: begin
                frame_high = b;
                frame_sum = frame_sum + b;
                phase = PH_LOW;
            end
            PH_LOW: begin
                frame_low = b;
                frame_sum = frame_sum + b;
                phase = PH_CHECK;
            end
            PH_CHECK: begin
                if (frame_sum == b && frame_command == command_sel) begin
                    positions_due.push_back({frame_high, frame_low});
                end
                phase = PH_HUNT;
            end
            default: begin
                phase = (b == SYNC_BYTE) ? PH_SYNCED : PH_HUNT;
            end
        endcase
    endfunction

    always @(posedge aclk) begin
        logic [POSITION_W-1:0] want;
        if (!aresetn) begin
            address_sel = EXPECTED_ADDRESS_RST;
            command_sel = WANTED_COMMAND_RST;
            phase = PH_HUNT;
            frame_sum = '0;
            frame_command = '0;
            frame_high = '0;
            frame_low = '0;
            positions_due.delete();
            mismatches = 0;
            positions_outstanding = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_EXPECTED_ADDRESS: address_sel = cfg_wdata;
                    CFG_WANTED_COMMAND:   command_sel = cfg_wdata;
                    default: ;
                endcase
            end
            // compare results before taking this edge's byte
            if (m_valid && m_ready) begin
                if (positions_due.size() == 0) begin
                    report_mismatch($sformatf("position beat 0x%04h with no reply pending",
                                              m_position_value));
                end else begin
                    want = positions_due.pop_front();
                    if (m_position_value !== want) begin
                        report_mismatch($sformatf("position beat 0x%04h, expected 0x%04h",
                                                  m_position_value, want));
                    end
                end
            end
            if (s_valid && s_ready) begin
                take_reply_byte(s_rx_byte);
            end
            positions_outstanding = positions_due.size();
        end
    end

endmodule

### tb/camera_zoom_reply_deframer_top_test.sv
// Top of the camera zoom reply deframer test: clock, reset, config writes,
// reply byte stimulus with random gaps and result back-pressure, and verdict.
// Depends on czrd_pkg, camera_zoom_reply_deframer_top and czrd_reply_checker.
module camera_zoom_reply_deframer_top_test
    import czrd_pkg::*;
();

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 8;
    localparam int MAX_GAP       = 18;
    localparam int RANDOM_BYTES  = 1900;
    localparam int PHASES        = 6;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [BYTE_W-1:0]     s_rx_byte = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [POSITION_W-1:0] m_position_value;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_EXPECTED_ADDRESS;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    int unsigned           mismatches;
    int unsigned           positions_outstanding;
    int unsigned           cycle_count = 0;
    int unsigned           bytes_sent = 0;
    int                    send_burst = 0;
    int                    take_burst = 0;
    logic [BYTE_W-1:0]     cur_address = EXPECTED_ADDRESS_RST;
    logic [BYTE_W-1:0]     cur_command = WANTED_COMMAND_RST;

    camera_zoom_reply_deframer_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_position_value (m_position_value),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata)
    );

    czrd_reply_checker reply_check (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_rx_byte             (s_rx_byte),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_position_value      (m_position_value),
        .cfg_we                (cfg_we),
        .cfg_index             (cfg_index),
        .cfg_wdata             (cfg_wdata),
        .mismatches            (mismatches),
        .positions_outstanding (positions_outstanding)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int draw_gap(inout int burst);
        if (burst == 0 && $urandom_range(0, 15) == 0) begin
            burst = $urandom_range(8, 40);
        end
        if (burst > 0) begin
            burst--;
            return 0;
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    function automatic logic [BYTE_W-1:0] reply_sum(input logic [BYTE_W-1:0] a, c1, c2,
                                                    hi, lo);
        return a + c1 + c2 + hi + lo;
    endfunction

    function automatic logic [BYTE_W-1:0] data_byte();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0) return 8'h00;
        if (pick == 1) return 8'hFF;
        return 8'($urandom);
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = draw_gap(send_burst);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!(s_valid && s_ready));
        @(negedge aclk);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [BYTE_W-1:0] a, c1, c2, hi, lo, skew);
        send_byte(SYNC_BYTE);
        send_byte(a);
        send_byte(c1);
        send_byte(c2);
        send_byte(hi);
        send_byte(lo);
        send_byte(reply_sum(a, c1, c2, hi, lo) + skew);
    endtask

    // hold input until every predicted position beat has been taken
    task automatic settle();
        s_valid <= 1'b0;
        while (positions_outstanding != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic configure(input logic [BYTE_W-1:0] a, c);
        settle();
        cfg_we <= 1'b1;
        cfg_index <= CFG_EXPECTED_ADDRESS;
        cfg_wdata <= a;
        @(negedge aclk);
        cfg_index <= CFG_WANTED_COMMAND;
        cfg_wdata <= c;
        @(negedge aclk);
        cfg_we <= 1'b0;
        cur_address = a;
        cur_command = c;
    endtask

    task automatic send_random_traffic();
        int pick;
        logic [BYTE_W-1:0] hi;
        logic [BYTE_W-1:0] lo;
        pick = $urandom_range(0, 99);
        hi = data_byte();
        lo = data_byte();
        if (pick < 55) begin
            if (cur_address != SYNC_BYTE && $urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 3)) send_byte(SYNC_BYTE);
            end
            send_frame(cur_address, 8'($urandom), cur_command, hi, lo, 8'h00);
        end else if (pick < 65) begin
            send_frame(cur_address, 8'($urandom),
                       cur_command + 8'($urandom_range(1, 255)), hi, lo, 8'h00);
        end else if (pick < 75) begin
            send_frame(cur_address, 8'($urandom), cur_command, hi, lo,
                       8'($urandom_range(1, 255)));
        end else if (pick < 85) begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
        end else if (pick < 93) begin
            send_byte(SYNC_BYTE);
            send_byte(cur_address);
            repeat ($urandom_range(0, 4)) send_byte(8'($urandom));
        end else begin
            send_byte(SYNC_BYTE);
            send_byte(cur_address + 8'($urandom_range(1, 255)));
        end
    endtask

    initial begin : result_sink
        int gap;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            gap = draw_gap(take_burst);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            @(negedge aclk);
        end
    end

    initial begin : reply_source
        int unsigned directed_bytes;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // repeated sync ahead of a frame, all-zero data
        send_byte(SYNC_BYTE);
        send_frame(EXPECTED_ADDRESS_RST, 8'h00, WANTED_COMMAND_RST, 8'h00, 8'h00, 8'h00);
        // sync bytes inside the frame, checksum equal to the sync byte
        send_frame(EXPECTED_ADDRESS_RST, SYNC_BYTE, WANTED_COMMAND_RST, SYNC_BYTE, 8'h93,
                   8'h00);
        send_byte(EXPECTED_ADDRESS_RST);
        send_frame(EXPECTED_ADDRESS_RST, 8'h00, WANTED_COMMAND_RST - 8'h01, 8'h12, 8'h34,
                   8'h00);
        send_frame(EXPECTED_ADDRESS_RST, 8'h00, WANTED_COMMAND_RST, 8'h12, 8'h34, 8'h01);
        // address equal to the sync byte
        configure(SYNC_BYTE, 8'h00);
        send_frame(SYNC_BYTE, 8'h00, 8'h00, SYNC_BYTE, SYNC_BYTE, 8'h00);
        directed_bytes = bytes_sent;

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                1:       configure(8'h00, 8'h00);
                2:       configure(SYNC_BYTE, SYNC_BYTE);
                3:       configure(EXPECTED_ADDRESS_RST, WANTED_COMMAND_RST);
                4:       configure(SYNC_BYTE, 8'($urandom));
                default: configure(8'($urandom), 8'($urandom));
            endcase
            while (bytes_sent < directed_bytes + (phase + 1) * RANDOM_BYTES / PHASES) begin
                send_random_traffic();
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0 && positions_outstanding == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### camera_zoom_reply_deframer_top.f
rtl/core/czrd_pkg.sv
rtl/core/czrd_parser.sv
rtl/core/czrd_result_stage.sv
rtl/core/camera_zoom_reply_deframer_top.sv
tb/czrd_reply_checker.sv
tb/camera_zoom_reply_deframer_top_test.sv
